@@ hw/rtl/acoustic_fdtd_grid_step_macros.svh @@
// assertion macros shared by the grid step rtl
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef ACOUSTIC_FDTD_GRID_STEP_MACROS_SVH
`define ACOUSTIC_FDTD_GRID_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define AFG_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("afg check failed");
`define AFG_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("afg check failed");
`else
`define AFG_ASSERT(lbl, clk, rst, prop)
`define AFG_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

@@ hw/rtl/afg_pkg.sv @@
// shared constants, codes, command types and helpers for the grid step block
// no dependencies
package afg_pkg;

  localparam int GRID_X_DEF = 16;
  localparam int GRID_Y_DEF = 16;
  localparam int GRID_Z_DEF = 16;

  // widths sized for the largest allowed grid (64 per side)
  localparam int COORD_W = 7;
  localparam int CLR_W   = 19;
  localparam int MAG_W   = 34;
  localparam int R_W     = 52;
  localparam int WIDE_W  = 56;

  localparam logic [31:0] VEL_RST  = 32'd79;
  localparam logic [31:0] PRES_RST = 32'd13500416;
  localparam logic [15:0] DAMP_RST = 16'd66;

  localparam logic [1:0] REG_VEL  = 2'd0;
  localparam logic [1:0] REG_PRES = 2'd1;
  localparam logic [1:0] REG_DAMP = 2'd2;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_STEP = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [3:0] DP_IDLE  = 4'd0;
  localparam logic [3:0] DP_CLEAR = 4'd1;
  localparam logic [3:0] DP_RD    = 4'd2;
  localparam logic [3:0] DP_LOAD  = 4'd3;
  localparam logic [3:0] DP_MHI   = 4'd4;
  localparam logic [3:0] DP_MLO   = 4'd5;
  localparam logic [3:0] DP_DAMP  = 4'd6;
  localparam logic [3:0] DP_WB    = 4'd7;
  localparam logic [3:0] DP_RES   = 4'd8;

  localparam logic [2:0] PASS_X    = 3'd0;
  localparam logic [2:0] PASS_Y    = 3'd1;
  localparam logic [2:0] PASS_Z    = 3'd2;
  localparam logic [2:0] PASS_P    = 3'd3;
  localparam logic [2:0] PASS_ADD  = 3'd4;
  localparam logic [2:0] PASS_READ = 3'd5;

  localparam logic [1:0] COEF_VEL  = 2'd0;
  localparam logic [1:0] COEF_PRES = 2'd1;
  localparam logic [1:0] COEF_DAMP = 2'd2;

  typedef struct packed {
    logic [3:0]         op;
    logic [2:0]         pass;
    logic [1:0]         coef;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [CLR_W-1:0]   clr_addr;
    logic signed [31:0] amount;
    logic               res_oor;
    logic               res_mem;
  } afg_cmd_t;

  typedef struct packed {
    logic out_free;
  } afg_stat_t;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(32'sh7fffffff);
  localparam logic signed [WIDE_W-1:0] SAT_MIN = WIDE_W'(32'sh80000000);

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    if (v > SAT_MAX) return 32'sh7fffffff;
    if (v < SAT_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

@@ hw/rtl/afg_if.sv @@
// valid/ready channels for input items and result words
// depends on nothing
interface afg_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [3:0]         cell_x;
  logic [3:0]         cell_y;
  logic [3:0]         cell_z;
  logic signed [31:0] amount;
  modport source(output valid, mode, cell_x, cell_y, cell_z, amount, input ready);
  modport sink(input valid, mode, cell_x, cell_y, cell_z, amount, output ready);
endinterface

interface afg_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pressure_value;
  logic               out_of_range;
  modport source(output valid, pressure_value, out_of_range, input ready);
  modport sink(input valid, pressure_value, out_of_range, output ready);
endinterface

@@ hw/rtl/afg_dp.sv @@
// datapath: grid memories, shared coefficient multiplier, result register
// depends on afg_pkg and afg_if
module afg_dp
  import afg_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF,
  parameter int GRID_Z = GRID_Z_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  afg_cmd_t    cmd,
  input  logic [31:0] vel_coeff,
  input  logic [31:0] pres_coeff,
  input  logic [15:0] damping,
  output afg_stat_t   stat,
  afg_result_if.source result
);

  localparam int NCELL = GRID_X * GRID_Y * GRID_Z;
  localparam int NFX   = (GRID_X + 1) * GRID_Y * GRID_Z;
  localparam int NFY   = GRID_X * (GRID_Y + 1) * GRID_Z;
  localparam int NFZ   = GRID_X * GRID_Y * (GRID_Z + 1);
  localparam int PAW   = $clog2(NCELL);
  localparam int XAW   = $clog2(NFX);
  localparam int YAW   = $clog2(NFY);
  localparam int ZAW   = $clog2(NFZ);

  function automatic int cidx(input int x, input int y, input int z);
    return x + GRID_X * (y + GRID_Y * z);
  endfunction
  function automatic int fxidx(input int x, input int y, input int z);
    return x + (GRID_X + 1) * (y + GRID_Y * z);
  endfunction
  function automatic int fyidx(input int x, input int y, input int z);
    return x + GRID_X * (y + (GRID_Y + 1) * z);
  endfunction

  logic signed [31:0] pmem [NCELL];
  logic signed [31:0] vxm  [NFX];
  logic signed [31:0] vym  [NFY];
  logic signed [31:0] vzm  [NFZ];

  int xi, yi, zi;
  logic [PAW-1:0] p_a0, p_a1;
  logic [XAW-1:0] vx_a0, vx_a1;
  logic [YAW-1:0] vy_a0, vy_a1;
  logic [ZAW-1:0] vz_a0, vz_a1;

  always_comb begin
    xi = int'(cmd.x);
    yi = int'(cmd.y);
    zi = int'(cmd.z);
    p_a0  = PAW'(cidx(xi, yi, zi));
    case (cmd.pass)
      PASS_X:  p_a1 = PAW'(cidx(xi - 1, yi, zi));
      PASS_Y:  p_a1 = PAW'(cidx(xi, yi - 1, zi));
      PASS_Z:  p_a1 = PAW'(cidx(xi, yi, zi - 1));
      default: p_a1 = p_a0;
    endcase
    vx_a0 = XAW'(fxidx(xi, yi, zi));
    vx_a1 = XAW'(fxidx(xi + 1, yi, zi));
    vy_a0 = YAW'(fyidx(xi, yi, zi));
    vy_a1 = YAW'(fyidx(xi, yi + 1, zi));
    vz_a0 = ZAW'(cidx(xi, yi, zi));
    vz_a1 = ZAW'(cidx(xi, yi, zi + 1));
  end

  // registered reads
  logic signed [31:0] rp0, rp1, rvx0, rvx1, rvy0, rvy1, rvz0, rvz1;
  always_ff @(posedge clk) begin
    if (cmd.op == DP_RD) begin
      rp0  <= pmem[p_a0];
      rp1  <= pmem[p_a1];
      rvx0 <= vxm[vx_a0];
      rvx1 <= vxm[vx_a1];
      rvy0 <= vym[vy_a0];
      rvy1 <= vym[vy_a1];
      rvz0 <= vzm[vz_a0];
      rvz1 <= vzm[vz_a1];
    end
  end

  // arithmetic registers
  logic [MAG_W-1:0]         mag;
  logic                     neg;
  logic signed [31:0]       old;
  logic [49:0]              hi;
  logic [R_W-1:0]           r;
  logic signed [WIDE_W-1:0] r_pres;

  logic [31:0]              coef;
  logic signed [32:0]       d;
  logic signed [34:0]       div, val;
  logic [34:0]              val_abs;
  logic signed [32:0]       old_ext;
  logic [32:0]              old_abs;
  logic [48:0]              lo;
  logic signed [WIDE_W-1:0] r_s, new_wide;
  logic signed [31:0]       new_val;

  always_comb begin
    case (cmd.coef)
      COEF_VEL:  coef = vel_coeff;
      COEF_PRES: coef = pres_coeff;
      COEF_DAMP: coef = {16'b0, damping};
      default:   coef = 32'b0;
    endcase
    d   = {rp0[31], rp0} - {rp1[31], rp1};
    div = (35'(rvx1) - 35'(rvx0)) + (35'(rvy1) - 35'(rvy0)) + (35'(rvz1) - 35'(rvz0));
    val = (cmd.pass == PASS_P) ? div : 35'(d);
    val_abs = val[34] ? 35'(-val) : 35'(val);
    old_ext = {old[31], old};
    old_abs = old[31] ? 33'(-old_ext) : 33'(old_ext);
    lo  = 49'(coef * mag[15:0]) + 49'h8000;
    r_s = neg ? -$signed(WIDE_W'(r)) : $signed(WIDE_W'(r));
    case (cmd.pass)
      PASS_P:   new_wide = WIDE_W'(old) - r_pres - r_s;
      PASS_ADD: new_wide = WIDE_W'(rp0) + WIDE_W'(cmd.amount);
      default:  new_wide = WIDE_W'(old) - r_s;
    endcase
    new_val = sat32(new_wide);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        mag <= MAG_W'(val_abs);
        neg <= val[34];
        case (cmd.pass)
          PASS_X:  old <= rvx0;
          PASS_Y:  old <= rvy0;
          PASS_Z:  old <= rvz0;
          default: old <= rp0;
        endcase
      end
      DP_MHI:  hi <= 50'(coef * mag[MAG_W-1:16]);
      DP_MLO:  r  <= R_W'(hi) + R_W'(lo[48:16]);
      DP_DAMP: begin
        r_pres <= r_s;
        mag    <= MAG_W'(old_abs);
        neg    <= old[31];
      end
      default: ;
    endcase
  end

  // writes; clear pass zeroes every store one entry a cycle
  logic clr;
  logic wb;
  assign clr = (cmd.op == DP_CLEAR);
  assign wb  = (cmd.op == DP_WB);

  always_ff @(posedge clk) begin
    if (clr && int'(cmd.clr_addr) < NCELL) pmem[PAW'(cmd.clr_addr)] <= 32'sd0;
    else if (wb && (cmd.pass == PASS_P || cmd.pass == PASS_ADD)) pmem[p_a0] <= new_val;
  end
  always_ff @(posedge clk) begin
    if (clr && int'(cmd.clr_addr) < NFX) vxm[XAW'(cmd.clr_addr)] <= 32'sd0;
    else if (wb && cmd.pass == PASS_X) vxm[vx_a0] <= new_val;
  end
  always_ff @(posedge clk) begin
    if (clr && int'(cmd.clr_addr) < NFY) vym[YAW'(cmd.clr_addr)] <= 32'sd0;
    else if (wb && cmd.pass == PASS_Y) vym[vy_a0] <= new_val;
  end
  always_ff @(posedge clk) begin
    if (clr && int'(cmd.clr_addr) < NFZ) vzm[ZAW'(cmd.clr_addr)] <= 32'sd0;
    else if (wb && cmd.pass == PASS_Z) vzm[vz_a0] <= new_val;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.op == DP_RES) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.op == DP_RES) begin
      result.pressure_value <= cmd.res_mem ? rp0 : 32'sd0;
      result.out_of_range   <= cmd.res_oor;
    end
  end

  assign stat.out_free = !result.valid || result.ready;

endmodule

@@ hw/rtl/afg_ctrl.sv @@
// controller: clear sweep, item decode, per-element sequencing of the step passes
// depends on afg_pkg, afg_if and the macro header
`include "acoustic_fdtd_grid_step_macros.svh"
module afg_ctrl
  import afg_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF,
  parameter int GRID_Z = GRID_Z_DEF
) (
  input  logic      clk,
  input  logic      rst,
  afg_item_if.sink  item,
  input  afg_stat_t stat,
  output afg_cmd_t  cmd
);

  localparam int NFX   = (GRID_X + 1) * GRID_Y * GRID_Z;
  localparam int NFY   = GRID_X * (GRID_Y + 1) * GRID_Z;
  localparam int NFZ   = GRID_X * GRID_Y * (GRID_Z + 1);
  localparam int CLR_N = (NFX > NFY) ? ((NFX > NFZ) ? NFX : NFZ) : ((NFY > NFZ) ? NFY : NFZ);

  localparam logic [COORD_W-1:0] XMAX  = COORD_W'(GRID_X - 1);
  localparam logic [COORD_W-1:0] YMAX  = COORD_W'(GRID_Y - 1);
  localparam logic [COORD_W-1:0] ZMAX  = COORD_W'(GRID_Z - 1);
  localparam logic [COORD_W-1:0] C_ONE = COORD_W'(1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_MHI   = 4'd4;
  localparam logic [3:0] S_MLO   = 4'd5;
  localparam logic [3:0] S_DAMP  = 4'd6;
  localparam logic [3:0] S_WB    = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]         state;
  logic [2:0]         pass;
  logic               damp_ph;
  logic [COORD_W-1:0] x, y, z;
  logic [CLR_W-1:0]   clr;
  logic               res_oor, res_mem;
  logic signed [31:0] amount;

  logic in_grid;
  logic x_last, y_last, z_last;

  assign item.ready = (state == S_IDLE);
  assign in_grid = (int'(item.cell_x) < GRID_X) && (int'(item.cell_y) < GRID_Y) &&
                   (int'(item.cell_z) < GRID_Z);
  assign x_last = (x == XMAX);
  assign y_last = (y == YMAX);
  assign z_last = (z == ZMAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr     <= '0;
      damp_ph <= 1'b0;
      pass    <= PASS_X;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (int'(clr) == CLR_N - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (item.valid) begin
            x       <= COORD_W'(item.cell_x);
            y       <= COORD_W'(item.cell_y);
            z       <= COORD_W'(item.cell_z);
            amount  <= item.amount;
            res_oor <= 1'b0;
            res_mem <= 1'b0;
            damp_ph <= 1'b0;
            case (item.mode)
              MODE_ADD: begin
                pass    <= PASS_ADD;
                res_oor <= !in_grid;
                state   <= in_grid ? S_RD : S_FIN;
              end
              MODE_STEP: begin
                pass  <= PASS_X;
                x     <= C_ONE;
                y     <= '0;
                z     <= '0;
                state <= S_RD;
              end
              MODE_READ: begin
                pass    <= PASS_READ;
                res_oor <= !in_grid;
                res_mem <= in_grid;
                state   <= in_grid ? S_RD : S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_RD: begin
          case (pass)
            PASS_ADD:  state <= S_WB;
            PASS_READ: state <= S_FIN;
            default:   state <= S_LOAD;
          endcase
        end
        S_LOAD: state <= S_MHI;
        S_MHI:  state <= S_MLO;
        S_MLO:  state <= (pass == PASS_P && !damp_ph) ? S_DAMP : S_WB;
        S_DAMP: begin
          damp_ph <= 1'b1;
          state   <= S_MHI;
        end
        S_WB: begin
          damp_ph <= 1'b0;
          state   <= S_RD;
          if (pass == PASS_ADD) begin
            state <= S_FIN;
          end else if (!x_last) begin
            x <= x + 1'b1;
          end else begin
            x <= (pass == PASS_X) ? C_ONE : '0;
            if (!y_last) begin
              y <= y + 1'b1;
            end else begin
              y <= (pass == PASS_Y) ? C_ONE : '0;
              if (!z_last) begin
                z <= z + 1'b1;
              end else begin
                case (pass)
                  PASS_X: begin
                    pass <= PASS_Y;
                    x    <= '0;
                    y    <= C_ONE;
                    z    <= '0;
                  end
                  PASS_Y: begin
                    pass <= PASS_Z;
                    x    <= '0;
                    y    <= '0;
                    z    <= C_ONE;
                  end
                  PASS_Z: begin
                    pass <= PASS_P;
                    x    <= '0;
                    y    <= '0;
                    z    <= '0;
                  end
                  default: state <= S_FIN;
                endcase
              end
            end
          end
        end
        S_FIN: if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.pass     = pass;
    cmd.x        = x;
    cmd.y        = y;
    cmd.z        = z;
    cmd.clr_addr = clr;
    cmd.amount   = amount;
    cmd.res_oor  = res_oor;
    cmd.res_mem  = res_mem;
    if (pass == PASS_P) cmd.coef = damp_ph ? COEF_DAMP : COEF_PRES;
    else cmd.coef = COEF_VEL;
    case (state)
      S_CLEAR: cmd.op = DP_CLEAR;
      S_RD:    cmd.op = DP_RD;
      S_LOAD:  cmd.op = DP_LOAD;
      S_MHI:   cmd.op = DP_MHI;
      S_MLO:   cmd.op = DP_MLO;
      S_DAMP:  cmd.op = DP_DAMP;
      S_WB:    cmd.op = DP_WB;
      S_FIN:   cmd.op = stat.out_free ? DP_RES : DP_IDLE;
      default: cmd.op = DP_IDLE;
    endcase
  end

  `AFG_ASSERT(a_res_free, clk, rst, (cmd.op == DP_RES) |-> stat.out_free)
  `AFG_ASSERT_NEXT(a_step_start, clk, rst, item.valid && item.ready && item.mode == MODE_STEP, state == S_RD && pass == PASS_X)
  `AFG_ASSERT(a_cell_damped, clk, rst, (state == S_WB && pass == PASS_P) |-> damp_ph)

endmodule

@@ hw/rtl/acoustic_fdtd_grid_step.sv @@
// top level of the acoustic grid step block: config registers, controller, datapath
// depends on afg_pkg, afg_if, afg_ctrl and afg_dp
//
// usage
//   item channel (valid/ready) takes one word: mode, cell_x/y/z, amount.
//   mode 0 adds amount to a cell, mode 1 runs one full time step,
//   mode 2 reads a cell; every word yields exactly one result word.
//   result channel (valid/ready) carries pressure_value and out_of_range
//   from an output register, so a stalled receiver only holds the block
//   once a second result is finished.
//   cfg port: cfg_we with cfg_index 0 vel_coeff, 1 pres_coeff, 2 damping;
//   write only while idle, other indexes are ignored.
// sequencing
//   one word is worked at a time; each store has one write port and two read addresses.
//   read: a read, then the result; add: a read, a write back, then the result.
//   step: per interior face a read, load, two multiplier passes and write
//   back; per cell the same, with a damping load and the multiplier passes
//   again (two coefficient products through the one shared multiplier).
// reset
//   rst clears control and loads the config defaults, then a clearing sweep
//   zeroes all stores, one entry a cycle over the largest face store
//   ((GX+1)*GY*GZ entries for a cube); no word is taken during it.
module acoustic_fdtd_grid_step
  import afg_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF,
  parameter int GRID_Z = GRID_Z_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  afg_item_if.sink    item,
  afg_result_if.source result
);

  logic [31:0] vel_coeff;
  logic [31:0] pres_coeff;
  logic [15:0] damping;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vel_coeff  <= VEL_RST;
      pres_coeff <= PRES_RST;
      damping    <= DAMP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VEL:  vel_coeff  <= cfg_data;
        REG_PRES: pres_coeff <= cfg_data;
        REG_DAMP: damping    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  afg_cmd_t  cmd;
  afg_stat_t stat;

  // sequencer: clear sweep and pass/element stepping
  afg_ctrl #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_ctrl (
    .clk (clk),
    .rst (rst),
    .item(item),
    .stat(stat),
    .cmd (cmd)
  );

  // memories, multiplier and result register
  afg_dp #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .vel_coeff (vel_coeff),
    .pres_coeff(pres_coeff),
    .damping   (damping),
    .stat      (stat),
    .result    (result)
  );

endmodule

@@ tb/tb.sv @@
// testbench for acoustic_fdtd_grid_step: add, time step, read and unused mode words
// depends on afg_pkg, afg_if (afg_item_if, afg_result_if) and the block's rtl
`timescale 1ns / 1ps

module tb;
  import afg_pkg::*;

  localparam int GX = 16;
  localparam int GY = 16;
  localparam int GZ = 16;
  localparam int NCELL = GX * GY * GZ;
  localparam int NFX = (GX + 1) * GY * GZ;
  localparam int NFY = GX * (GY + 1) * GZ;
  localparam int NFZ = GX * GY * (GZ + 1);
  // unused mode and register codes: the register code is ignored, the mode gets a zero result
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic [1:0] REG_NONE  = 2'd3;
  // a full step runs with nothing accepted
  localparam int QUIET_LIMIT = 500000;
  localparam int MAX_STEPS   = 4;

  typedef struct {
    logic [1:0]         mode;
    logic [3:0]         x;
    logic [3:0]         y;
    logic [3:0]         z;
    logic signed [31:0] amount;
  } word_t;

  typedef struct {
    logic signed [31:0] pv;
    logic               oor;
  } outcome_t;

  logic clk;
  logic rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  afg_item_if   item ();
  afg_result_if result ();

  acoustic_fdtd_grid_step u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (item.sink),
    .result   (result.source)
  );

  // shadow of the block's coefficients and stores
  logic [31:0] sh_vel;
  logic [31:0] sh_pres;
  logic [15:0] sh_damp;
  int pres_grid [NCELL];
  int vel_x [NFX];
  int vel_y [NFY];
  int vel_z [NFZ];

  word_t    pending_words [$];
  outcome_t expected_results [$];
  int  errors;
  bit  calm;      // no idling in the tail of the run
  int  send_gap;
  int  recv_gap;
  int  quiet;

  function automatic int clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  // coefficient product >> 16, rounded half away from zero on the magnitude
  function automatic longint scale_q16(input longint unsigned c, input longint v);
    longint unsigned m;
    longint unsigned r;
    m = (v < 0) ? longint'(-v) : longint'(v);
    r = c * (m >> 16) + ((c * (m & 64'hffff) + 64'h8000) >> 16);
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic int cell_at(input int x, input int y, input int z);
    return x + GX * (y + GY * z);
  endfunction

  function automatic void advance_wave();
    longint d;
    longint p;
    longint dv;
    int c;
    for (int z = 0; z < GZ; z++)
      for (int y = 0; y < GY; y++)
        for (int x = 1; x < GX; x++) begin
          d = longint'(pres_grid[cell_at(x, y, z)]) - pres_grid[cell_at(x - 1, y, z)];
          c = x + (GX + 1) * (y + GY * z);
          vel_x[c] = clamp32(longint'(vel_x[c]) - scale_q16(sh_vel, d));
        end
    for (int z = 0; z < GZ; z++)
      for (int y = 1; y < GY; y++)
        for (int x = 0; x < GX; x++) begin
          d = longint'(pres_grid[cell_at(x, y, z)]) - pres_grid[cell_at(x, y - 1, z)];
          c = x + GX * (y + (GY + 1) * z);
          vel_y[c] = clamp32(longint'(vel_y[c]) - scale_q16(sh_vel, d));
        end
    for (int z = 1; z < GZ; z++)
      for (int y = 0; y < GY; y++)
        for (int x = 0; x < GX; x++) begin
          d = longint'(pres_grid[cell_at(x, y, z)]) - pres_grid[cell_at(x, y, z - 1)];
          c = cell_at(x, y, z);
          vel_z[c] = clamp32(longint'(vel_z[c]) - scale_q16(sh_vel, d));
        end
    for (int z = 0; z < GZ; z++)
      for (int y = 0; y < GY; y++)
        for (int x = 0; x < GX; x++) begin
          c = cell_at(x, y, z);
          p = pres_grid[c];
          dv = (longint'(vel_x[(x + 1) + (GX + 1) * (y + GY * z)])
                - vel_x[x + (GX + 1) * (y + GY * z)])
             + (longint'(vel_y[x + GX * ((y + 1) + (GY + 1) * z)])
                - vel_y[x + GX * (y + (GY + 1) * z)])
             + (longint'(vel_z[cell_at(x, y, z + 1)]) - vel_z[cell_at(x, y, z)]);
          pres_grid[c] = clamp32(p - scale_q16(sh_pres, dv) - scale_q16(sh_damp, p));
        end
  endfunction

  // applies one accepted word to the shadow and returns its result word
  function automatic outcome_t predict_word(input word_t w);
    outcome_t o;
    int c;
    o.pv = '0;
    o.oor = 1'b0;
    c = cell_at(w.x, w.y, w.z);
    // coordinates are 4 bits wide, so every cell of a 16 cube is in range
    case (w.mode)
      MODE_ADD: pres_grid[c] = clamp32(longint'(pres_grid[c]) + longint'(w.amount));
      MODE_STEP: advance_wave();
      MODE_READ: o.pv = pres_grid[c];
      default: ;
    endcase
    return o;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: one word from the pending queue at a time, random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (item.valid && item.ready)
        expected_results.push_back(predict_word('{item.mode, item.cell_x, item.cell_y,
                                                 item.cell_z, item.amount}));
      if (!item.valid || item.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          item.valid <= 1'b0;
        end else if (pending_words.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 13);
          item.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          word_t w;
          w = pending_words.pop_front();
          item.valid <= 1'b1;
          item.mode <= w.mode;
          item.cell_x <= w.x;
          item.cell_y <= w.y;
          item.cell_z <= w.z;
          item.amount <= w.amount;
        end else begin
          item.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result word with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word pv=%0d oor=%0b", $time,
                   result.pressure_value, result.out_of_range);
          errors++;
        end else begin
          outcome_t e;
          e = expected_results.pop_front();
          if (result.pressure_value !== e.pv) begin
            $display("%0t: pressure_value expected %0d actual %0d", $time, e.pv,
                     result.pressure_value);
            errors++;
          end
          if (result.out_of_range !== e.oor) begin
            $display("%0t: out_of_range expected %0b actual %0b", $time, e.oor,
                     result.out_of_range);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        result.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 13);
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic queue_word(input logic [1:0] mode, input int x, input int y, input int z,
                            input logic [31:0] amount);
    pending_words.push_back('{mode, x[3:0], y[3:0], z[3:0], amount});
  endtask

  // register writes happen only here, with the block drained
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_VEL:  sh_vel = value;
      REG_PRES: sh_pres = value;
      REG_DAMP: sh_damp = value[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // holds off until every word is sent and every result is back
  task automatic drain();
    while (pending_words.size() > 0 || item.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reads_around(input int x, input int y, input int z);
    queue_word(MODE_READ, x, y, z, $urandom);
    queue_word(MODE_READ, (x + 1) % GX, y, z, $urandom);
    queue_word(MODE_READ, x, (y + 1) % GY, z, $urandom);
    queue_word(MODE_READ, x, y, (z + 1) % GZ, $urandom);
  endtask

  initial begin
    int steps;
    int m;
    errors = 0;
    calm = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item.valid = 1'b0;
    item.mode = '0;
    item.cell_x = '0;
    item.cell_y = '0;
    item.cell_z = '0;
    item.amount = '0;
    result.ready = 1'b0;
    sh_vel = VEL_RST;
    sh_pres = PRES_RST;
    sh_damp = DAMP_RST;
    foreach (pres_grid[i]) pres_grid[i] = 0;
    foreach (vel_x[i]) vel_x[i] = 0;
    foreach (vel_y[i]) vel_y[i] = 0;
    foreach (vel_z[i]) vel_z[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: saturation both ways, corner cells, unused mode, steps at reset values
    queue_word(MODE_READ, 3, 3, 3, 32'h0);
    queue_word(MODE_ADD, 0, 0, 0, 32'h7fffffff);
    queue_word(MODE_ADD, 0, 0, 0, 32'h7fffffff);
    queue_word(MODE_READ, 0, 0, 0, 32'h0);
    queue_word(MODE_ADD, 15, 15, 15, 32'h80000000);
    queue_word(MODE_ADD, 15, 15, 15, 32'h80000000);
    queue_word(MODE_READ, 15, 15, 15, 32'hffffffff);
    queue_word(MODE_ADD, 7, 8, 9, 32'h0005_8000);
    queue_word(MODE_ADD, 7, 8, 9, 32'hffff_0000);
    queue_word(MODE_NONE, 7, 8, 9, 32'h1234_5678);
    queue_word(MODE_READ, 7, 8, 9, 32'h0);
    queue_word(MODE_STEP, 15, 0, 15, 32'h0);
    reads_around(7, 8, 9);
    queue_word(MODE_READ, 1, 0, 0, 32'h0);
    queue_word(MODE_READ, 14, 15, 15, 32'h0);
    queue_word(MODE_STEP, 0, 0, 0, 32'h0);
    reads_around(0, 0, 0);
    drain();

    // largest coefficients, plus a write to a register index that does not exist
    write_reg(REG_VEL, 32'hffffffff);
    write_reg(REG_PRES, 32'hffffffff);
    write_reg(REG_DAMP, 32'h0000ffff);
    write_reg(REG_NONE, 32'h0000_0001);
    queue_word(MODE_ADD, 4, 5, 6, 32'h0000_0001);
    queue_word(MODE_ADD, 10, 2, 12, 32'hffff_fff0);
    queue_word(MODE_STEP, 4, 5, 6, 32'h0);
    reads_around(4, 5, 6);
    reads_around(9, 2, 12);
    drain();

    // zero coefficients: velocities and pressures freeze across a step
    write_reg(REG_VEL, 32'h0);
    write_reg(REG_PRES, 32'h0);
    write_reg(REG_DAMP, 32'h0);
    queue_word(MODE_ADD, 2, 2, 2, $urandom);
    queue_word(MODE_STEP, 0, 0, 0, 32'h0);
    reads_around(2, 2, 2);
    reads_around(0, 0, 0);
    drain();

    // random coefficients in a physically sensible range, then random words
    write_reg(REG_VEL, $urandom_range(0, 32'h0000_4000));
    write_reg(REG_PRES, $urandom_range(0, 32'h0400_0000));
    write_reg(REG_DAMP, $urandom_range(0, 16'h0800));
    steps = 0;
    for (int i = 0; i < 60; i++) begin
      m = $urandom_range(0, 99);
      if (m < 5 && steps < MAX_STEPS) begin
        steps++;
        queue_word(MODE_STEP, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 15), $urandom);
      end else if (m < 50) begin
        queue_word(MODE_ADD, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 15), $urandom);
      end else if (m < 97) begin
        queue_word(MODE_READ, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 15), $urandom);
      end else begin
        queue_word(MODE_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 15), $urandom);
      end
    end
    while (pending_words.size() > 15) @(posedge clk);
    calm = 1'b1;
    while (pending_words.size() > 0 || item.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
